[hw/rtl/jtkl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key lookup package
// Shared constants, types and character classes of the top-level key lookup.
// ----------------------------------------------------------------------------
package jtkl_pkg;

  localparam int MAX_DEPTH_DEFAULT     = 32;
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int MAX_KEY_BYTES_DEFAULT = 8;

  localparam int KEY_WIDTH     = 64;
  localparam int KEY_LEN_WIDTH = 4;
  localparam int OFFSET_WIDTH  = 16;
  localparam int LENGTH_WIDTH  = 16;

  localparam logic [0:0] REG_KEY_BYTES  = 1'b0;
  localparam logic [0:0] REG_KEY_LENGTH = 1'b1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [3:0] {
    PH_OPEN,
    PH_MEMBER,
    PH_KEY,
    PH_COLON,
    PH_VALSTART,
    PH_SCALAR,
    PH_STRING,
    PH_CONTAINER,
    PH_DELIM,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic [OFFSET_WIDTH-1:0]   offset;
    logic [LENGTH_WIDTH-1:0]   length;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return c inside {CH_LBRACE, CH_LBRACKET};
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return c inside {CH_RBRACE, CH_RBRACKET};
  endfunction

  function automatic logic is_scalar_end(input logic [7:0] c);
    return (c inside {CH_COMMA, CH_RBRACE, CH_RBRACKET}) || is_ws(c);
  endfunction

endpackage

[hw/rtl/jtkl_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key lookup input register
// Holds one input word until the parser takes it.
// ----------------------------------------------------------------------------
module jtkl_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jtkl_pkg::in_word_t in_word,
  input  logic               advance,
  output logic               word_valid,
  output jtkl_pkg::in_word_t word
);

  logic load;

  assign in_stall = word_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= in_word;
    end
  end

endmodule

[hw/rtl/jtkl_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key lookup parser
// Parser state registers and the per-byte state update and decision logic.
// ----------------------------------------------------------------------------
module jtkl_parser #(
  parameter int MAX_DEPTH     = jtkl_pkg::MAX_DEPTH_DEFAULT,
  parameter int POSITION_BITS = jtkl_pkg::POSITION_BITS_DEFAULT,
  parameter int MAX_KEY_BYTES = jtkl_pkg::MAX_KEY_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  jtkl_pkg::in_word_t                 word,
  input  logic [8*MAX_KEY_BYTES-1:0]         key,
  input  logic [jtkl_pkg::KEY_LEN_WIDTH-1:0] key_length,
  output logic                               emit,
  output jtkl_pkg::result_t                  result
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int PB = POSITION_BITS;
  localparam int KL = jtkl_pkg::KEY_LEN_WIDTH;

  jtkl_pkg::phase_t phase, phase_next;
  logic [DW-1:0]    depth, depth_next;
  logic [PB:0]      pos, pos_next;
  logic [PB-1:0]    vstart, vstart_next;
  logic [KL-1:0]    kseen, kseen_next;
  logic             kmatch, kmatch_next;
  logic             esc, esc_next;

  logic [7:0]       c;
  logic [7:0]       key_sel;
  logic             key_miss;
  logic [PB:0]      pos_p1;
  logic [DW-1:0]    depth_dec;
  logic [PB-1:0]    val_begin;
  logic [PB:0]      val_end;
  logic [PB:0]      val_len;
  jtkl_pkg::status_t status;

  assign c      = word.data;
  assign pos_p1 = pos + 1'b1;

  always_comb begin
    key_sel = '0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (kseen == KL'(i)) begin
        key_sel = key[8*i +: 8];
      end
    end
  end

  assign key_miss  = (kseen >= key_length) || (kseen >= KL'(MAX_KEY_BYTES)) || (key_sel != c);
  assign depth_dec = (depth != '0) ? depth - 1'b1 : depth;
  assign val_len   = val_end - {1'b0, val_begin};

  always_comb begin
    phase_next  = phase;
    depth_next  = depth;
    pos_next    = pos;
    vstart_next = vstart;
    kseen_next  = kseen;
    kmatch_next = kmatch;
    esc_next    = esc;
    emit        = 1'b0;
    status      = jtkl_pkg::ST_MALFORMED;
    val_begin   = vstart;
    val_end     = pos;

    if (phase != jtkl_pkg::PH_DONE) begin
      if (pos[PB]) begin
        emit = 1'b1;
      end else begin
        case (phase)
          jtkl_pkg::PH_OPEN: begin
            if (c == jtkl_pkg::CH_LBRACE) begin
              phase_next = jtkl_pkg::PH_MEMBER;
            end else if (!jtkl_pkg::is_ws(c)) begin
              emit = 1'b1;
            end
          end
          jtkl_pkg::PH_MEMBER: begin
            if (c == jtkl_pkg::CH_RBRACE) begin
              emit   = 1'b1;
              status = jtkl_pkg::ST_ABSENT;
            end else if (c == jtkl_pkg::CH_QUOTE) begin
              phase_next  = jtkl_pkg::PH_KEY;
              kseen_next  = '0;
              kmatch_next = 1'b1;
              esc_next    = 1'b0;
            end else if (!jtkl_pkg::is_ws(c)) begin
              emit = 1'b1;
            end
          end
          jtkl_pkg::PH_KEY: begin
            if (!esc && c == jtkl_pkg::CH_QUOTE) begin
              kmatch_next = kmatch && (kseen == key_length);
              phase_next  = jtkl_pkg::PH_COLON;
            end else begin
              esc_next = !esc && (c == jtkl_pkg::CH_BACKSLASH);
              if (key_miss) begin
                kmatch_next = 1'b0;
              end
              if (kseen != '1) begin
                kseen_next = kseen + 1'b1;
              end
            end
          end
          jtkl_pkg::PH_COLON: begin
            if (c == jtkl_pkg::CH_COLON) begin
              phase_next = jtkl_pkg::PH_VALSTART;
            end else if (!jtkl_pkg::is_ws(c)) begin
              emit = 1'b1;
            end
          end
          jtkl_pkg::PH_VALSTART: begin
            if (!jtkl_pkg::is_ws(c)) begin
              vstart_next = pos[PB-1:0];
              depth_next  = '0;
              if (c == jtkl_pkg::CH_QUOTE) begin
                esc_next   = 1'b0;
                phase_next = jtkl_pkg::PH_STRING;
              end else if (jtkl_pkg::is_opener(c)) begin
                depth_next = DW'(1);
                phase_next = jtkl_pkg::PH_CONTAINER;
              end else if (jtkl_pkg::is_closer(c)) begin
                emit = 1'b1;
              end else if (c == jtkl_pkg::CH_COMMA) begin
                if (kmatch) begin
                  emit      = 1'b1;
                  status    = jtkl_pkg::ST_FOUND;
                  val_begin = pos[PB-1:0];
                  val_end   = pos;
                end else begin
                  phase_next = jtkl_pkg::PH_MEMBER;
                end
              end else begin
                phase_next = jtkl_pkg::PH_SCALAR;
              end
            end
          end
          jtkl_pkg::PH_SCALAR: begin
            if (jtkl_pkg::is_scalar_end(c)) begin
              if (kmatch) begin
                emit    = 1'b1;
                status  = jtkl_pkg::ST_FOUND;
                val_end = pos;
              end else if (jtkl_pkg::is_ws(c)) begin
                phase_next = jtkl_pkg::PH_DELIM;
              end else if (c == jtkl_pkg::CH_COMMA) begin
                phase_next = jtkl_pkg::PH_MEMBER;
              end else if (c == jtkl_pkg::CH_RBRACE) begin
                emit   = 1'b1;
                status = jtkl_pkg::ST_ABSENT;
              end else begin
                emit = 1'b1;
              end
            end
          end
          jtkl_pkg::PH_STRING: begin
            if (esc) begin
              esc_next = 1'b0;
            end else if (c == jtkl_pkg::CH_BACKSLASH) begin
              esc_next = 1'b1;
            end else if (c == jtkl_pkg::CH_QUOTE) begin
              if (depth != '0) begin
                phase_next = jtkl_pkg::PH_CONTAINER;
              end else if (kmatch) begin
                emit    = 1'b1;
                status  = jtkl_pkg::ST_FOUND;
                val_end = pos_p1;
              end else begin
                phase_next = jtkl_pkg::PH_DELIM;
              end
            end
          end
          jtkl_pkg::PH_CONTAINER: begin
            if (c == jtkl_pkg::CH_QUOTE) begin
              esc_next   = 1'b0;
              phase_next = jtkl_pkg::PH_STRING;
            end else if (jtkl_pkg::is_opener(c)) begin
              if (depth >= DW'(MAX_DEPTH)) begin
                emit = 1'b1;
              end else begin
                depth_next = depth + 1'b1;
              end
            end else if (jtkl_pkg::is_closer(c)) begin
              depth_next = depth_dec;
              if (depth_dec == '0) begin
                if (kmatch) begin
                  emit    = 1'b1;
                  status  = jtkl_pkg::ST_FOUND;
                  val_end = pos_p1;
                end else begin
                  phase_next = jtkl_pkg::PH_DELIM;
                end
              end
            end
          end
          jtkl_pkg::PH_DELIM: begin
            if (c == jtkl_pkg::CH_COMMA) begin
              phase_next = jtkl_pkg::PH_MEMBER;
            end else if (c == jtkl_pkg::CH_RBRACE) begin
              emit   = 1'b1;
              status = jtkl_pkg::ST_ABSENT;
            end else if (!jtkl_pkg::is_ws(c)) begin
              emit = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // A bare scalar cut off by the end of the buffer is complete.
      if (!emit && word.last) begin
        emit = 1'b1;
        if (phase_next == jtkl_pkg::PH_SCALAR && kmatch) begin
          status    = jtkl_pkg::ST_FOUND;
          val_begin = vstart_next;
          val_end   = pos_p1;
        end
      end

      if (emit) begin
        phase_next = jtkl_pkg::PH_DONE;
      end
    end

    if (word.last) begin
      phase_next  = jtkl_pkg::PH_OPEN;
      depth_next  = '0;
      pos_next    = '0;
      vstart_next = '0;
      kseen_next  = '0;
      kmatch_next = 1'b1;
      esc_next    = 1'b0;
    end else if (!pos[PB]) begin
      pos_next = pos_p1;
    end

    result.status = status;
    if (status == jtkl_pkg::ST_FOUND) begin
      result.offset = jtkl_pkg::OFFSET_WIDTH'(val_begin);
      result.length = jtkl_pkg::LENGTH_WIDTH'(val_len);
    end else begin
      result.offset = '0;
      result.length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= jtkl_pkg::PH_OPEN;
      depth  <= '0;
      pos    <= '0;
      vstart <= '0;
      kseen  <= '0;
      kmatch <= 1'b1;
      esc    <= 1'b0;
    end else if (advance) begin
      phase  <= phase_next;
      depth  <= depth_next;
      pos    <= pos_next;
      vstart <= vstart_next;
      kseen  <= kseen_next;
      kmatch <= kmatch_next;
      esc    <= esc_next;
    end
  end

endmodule

[hw/rtl/jtkl_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key lookup result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module jtkl_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jtkl_pkg::result_t result_in,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output jtkl_pkg::result_t result
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

[hw/rtl/json_top_level_key_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON top-level key lookup
// Looks up one member of a JSON object by its raw key and reports its value.
// ----------------------------------------------------------------------------
// The input channel takes one buffer byte per word, with last_byte marking the
// final byte of a buffer. Each buffer gives exactly one result word on the
// output channel: found with value offset and length, key absent, or
// malformed. The result appears at the byte that decides it; later bytes of
// the same buffer are taken and ignored up to the last byte.
// The wanted key is set through the write port (index 0 key bytes, index 1 key
// length); the user must do so only while the block is idle, not enforced here.
// A byte passes an input register and then the parser. A deciding byte's
// result word is loaded into the result register, from which the receiver
// takes it. One byte is taken every cycle unless a result waits for the
// receiver; the parser state update is the loop that sets this rate.
// Whilst the receiver stalls, bytes that decide nothing keep flowing; a byte
// that would give a second result waits in the input register, and the input
// channel stalls behind it.
// Reset returns the parser to the start of a buffer and clears the key
// registers; a buffer in flight is lost.
// ----------------------------------------------------------------------------
module json_top_level_key_lookup #(
  parameter int MAX_DEPTH     = jtkl_pkg::MAX_DEPTH_DEFAULT,
  parameter int POSITION_BITS = jtkl_pkg::POSITION_BITS_DEFAULT,
  parameter int MAX_KEY_BYTES = jtkl_pkg::MAX_KEY_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [0:0]                         cfg_index,
  input  logic [jtkl_pkg::KEY_WIDTH-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         lookup_status,
  output logic [jtkl_pkg::OFFSET_WIDTH-1:0]  value_offset,
  output logic [jtkl_pkg::LENGTH_WIDTH-1:0]  value_length
);

  logic [8*MAX_KEY_BYTES-1:0]         key;
  logic [jtkl_pkg::KEY_LEN_WIDTH-1:0] key_length;

  jtkl_pkg::in_word_t in_word;
  jtkl_pkg::in_word_t word;
  jtkl_pkg::result_t  parse_result;
  jtkl_pkg::result_t  result;
  logic               word_valid;
  logic               emit;
  logic               out_ready;
  logic               advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key        <= '0;
      key_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        jtkl_pkg::REG_KEY_BYTES: begin
          key <= cfg_data[8*MAX_KEY_BYTES-1:0];
        end
        jtkl_pkg::REG_KEY_LENGTH: begin
          key_length <= cfg_data[jtkl_pkg::KEY_LEN_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_word.data = data_byte;
  assign in_word.last = last_byte;

  assign advance = word_valid && (!emit || out_ready);

  jtkl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  jtkl_parser #(
    .MAX_DEPTH     (MAX_DEPTH),
    .POSITION_BITS (POSITION_BITS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .word       (word),
    .key        (key),
    .key_length (key_length),
    .emit       (emit),
    .result     (parse_result)
  );

  jtkl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .result_in (parse_result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign lookup_status = result.status;
  assign value_offset  = result.offset;
  assign value_length  = result.length;

endmodule
